// ===== sv/first_fit_block_allocator_macros.svh =====
// Assertion macros for the first-fit allocator checker.
// Both expect signals named clk and rst in the scope of use.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define FFBA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication.
`define FFBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ===== sv/ffba_pkg.sv =====
`default_nettype none
package ffba_pkg;

  localparam int NUM_BLOCKS_DEF = 8;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int AMOUNT_W = 16;
  localparam int INDEX_W  = 3;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_FIT    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PIECE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LOAD   = 2'd3;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [INDEX_W-1:0]  block_index;
    logic [AMOUNT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  chosen_block;
    logic [AMOUNT_W-1:0] amount_taken;
    logic [AMOUNT_W-1:0] block_left;
    logic                last;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic clr_idx;
    logic inc_idx;
    logic rd;
    logic acc_sum;
    logic load;
    logic fit;
    logic refuse;
    logic piece;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic mode;
    logic out_free;
    logic idx_last;
    logic fit_ok;
    logic sum_short;
    logic drain_take;
    logic drain_final;
  } stat_t;

endpackage
`default_nettype wire

// ===== sv/ffba_in_if.sv =====
`default_nettype none
interface ffba_in_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [ffba_pkg::INDEX_W-1:0]      block_index;
  logic [ffba_pkg::AMOUNT_W-1:0]     amount;

  modport source (output valid, mode, block_index, amount, input ready);
  modport sink   (input valid, mode, block_index, amount, output ready);
endinterface
`default_nettype wire

// ===== sv/ffba_out_if.sv =====
`default_nettype none
interface ffba_out_if;
  logic                              valid;
  logic                              ready;
  logic [ffba_pkg::STATUS_W-1:0]     status;
  logic [ffba_pkg::INDEX_W-1:0]      chosen_block;
  logic [ffba_pkg::AMOUNT_W-1:0]     amount_taken;
  logic [ffba_pkg::AMOUNT_W-1:0]     block_left;
  logic                              last;

  modport source (output valid, status, chosen_block, amount_taken, block_left, last,
                  input ready);
  modport sink   (input valid, status, chosen_block, amount_taken, block_left, last,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/ffba_ctrl.sv =====
`default_nettype none
module ffba_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ffba_pkg::stat_t stat,
  output ffba_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_LOAD    = 4'd2;
  localparam logic [3:0] S_RD_FIT  = 4'd3;
  localparam logic [3:0] S_EV_FIT  = 4'd4;
  localparam logic [3:0] S_RD_SUM  = 4'd5;
  localparam logic [3:0] S_EV_SUM  = 4'd6;
  localparam logic [3:0] S_SUM_CHK = 4'd7;
  localparam logic [3:0] S_RD_DRN  = 4'd8;
  localparam logic [3:0] S_EV_DRN  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.clr_idx = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = (stat.mode == ffba_pkg::MODE_LOAD) ? S_LOAD : S_RD_FIT;
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD_FIT: begin
        cmd.rd     = 1'b1;
        state_next = S_EV_FIT;
      end
      S_EV_FIT: begin
        if (stat.fit_ok) begin
          if (stat.out_free) begin
            cmd.fit    = 1'b1;
            state_next = S_IDLE;
          end
        end else if (stat.idx_last) begin
          cmd.clr_idx = 1'b1;
          state_next  = S_RD_SUM;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = S_RD_FIT;
        end
      end
      S_RD_SUM: begin
        cmd.rd     = 1'b1;
        state_next = S_EV_SUM;
      end
      S_EV_SUM: begin
        cmd.acc_sum = 1'b1;
        if (stat.idx_last) begin
          cmd.clr_idx = 1'b1;
          state_next  = S_SUM_CHK;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = S_RD_SUM;
        end
      end
      S_SUM_CHK: begin
        if (!stat.sum_short) begin
          state_next = S_RD_DRN;
        end else if (stat.out_free) begin
          cmd.refuse = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD_DRN: begin
        cmd.rd     = 1'b1;
        state_next = S_EV_DRN;
      end
      S_EV_DRN: begin
        if (stat.drain_take) begin
          if (stat.out_free) begin
            cmd.piece = 1'b1;
            if (stat.drain_final || stat.idx_last) begin
              state_next = S_IDLE;
            end else begin
              cmd.inc_idx = 1'b1;
              state_next  = S_RD_DRN;
            end
          end
        end else if (stat.idx_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = S_RD_DRN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ffba_dp.sv =====
`default_nettype none
module ffba_dp #(
  parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = ffba_pkg::SIZE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ffba_pkg::cmd_t       cmd,
  output ffba_pkg::stat_t           stat,
  input  wire ffba_pkg::in_item_t   in_item,
  output ffba_pkg::out_item_t       out_item,
  output logic                      out_valid,
  input  wire logic                 out_ready
);

  localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int SW = SIZE_BITS + $clog2(NUM_BLOCKS + 1);
  localparam int CW = (SW > ffba_pkg::AMOUNT_W) ? SW : ffba_pkg::AMOUNT_W;
  localparam logic [IW-1:0] IDX_MAX = IW'(NUM_BLOCKS - 1);

  ffba_pkg::in_item_t            req;
  logic [IW-1:0]                 idx;
  logic [SW-1:0]                 sum;
  logic [ffba_pkg::AMOUNT_W-1:0] rest;

  logic [SIZE_BITS-1:0]          mem [NUM_BLOCKS];
  logic [SIZE_BITS-1:0]          rd_data;
  logic                          rd_vld;
  logic                          rd_used;
  logic [NUM_BLOCKS-1:0]         cap_vld;
  logic [NUM_BLOCKS-1:0]         used;

  logic [SIZE_BITS-1:0]          cap;
  logic [CW-1:0]                 cap_x;
  logic [CW-1:0]                 amt_x;
  logic [CW-1:0]                 rest_x;
  logic [SIZE_BITS-1:0]          fit_left;
  logic [SIZE_BITS-1:0]          drain_left;
  logic                          in_range;
  logic [IW-1:0]                 load_addr;
  logic [SIZE_BITS-1:0]          load_cap;
  logic                          wr_en;
  logic [IW-1:0]                 wr_addr;
  logic [SIZE_BITS-1:0]          wr_data;
  logic                          emit;
  ffba_pkg::out_item_t           res;

  // Entries never loaded read as empty.
  assign cap    = rd_vld ? rd_data : '0;
  assign cap_x  = CW'(cap);
  assign amt_x  = CW'(req.amount);
  assign rest_x = CW'(rest);

  assign fit_left   = SIZE_BITS'(cap_x - amt_x);
  assign drain_left = SIZE_BITS'(cap_x - rest_x);

  assign in_range  = int'(req.block_index) < NUM_BLOCKS;
  assign load_addr = IW'(req.block_index);
  assign load_cap  = SIZE_BITS'(req.amount);

  assign stat.mode        = req.mode;
  assign stat.out_free    = !out_valid || out_ready;
  assign stat.idx_last    = (idx == IDX_MAX);
  assign stat.fit_ok      = (amt_x <= cap_x);
  assign stat.sum_short   = (CW'(sum) < amt_x);
  assign stat.drain_take  = rd_used && (cap != '0);
  assign stat.drain_final = (rest_x <= cap_x);

  assign wr_en   = (cmd.load && in_range) || cmd.fit || cmd.piece;
  assign wr_addr = cmd.load ? load_addr : idx;
  always_comb begin
    if (cmd.load) begin
      wr_data = load_cap;
    end else if (cmd.fit) begin
      wr_data = fit_left;
    end else if (stat.drain_final) begin
      wr_data = drain_left;
    end else begin
      wr_data = '0;
    end
  end

  assign emit = cmd.load || cmd.fit || cmd.refuse || cmd.piece;

  always_comb begin
    res.status       = ffba_pkg::ST_REFUSE;
    res.chosen_block = '0;
    res.amount_taken = '0;
    res.block_left   = '0;
    res.last         = 1'b1;
    if (cmd.load) begin
      res.status       = ffba_pkg::ST_LOAD;
      res.chosen_block = req.block_index;
      res.block_left   = in_range ? ffba_pkg::AMOUNT_W'(load_cap) : '0;
    end else if (cmd.fit) begin
      res.status       = ffba_pkg::ST_FIT;
      res.chosen_block = ffba_pkg::INDEX_W'(idx);
      res.amount_taken = req.amount;
      res.block_left   = ffba_pkg::AMOUNT_W'(fit_left);
    end else if (cmd.piece) begin
      res.status       = ffba_pkg::ST_PIECE;
      res.chosen_block = ffba_pkg::INDEX_W'(idx);
      res.amount_taken = stat.drain_final ? rest : ffba_pkg::AMOUNT_W'(cap);
      res.block_left   = stat.drain_final ? ffba_pkg::AMOUNT_W'(drain_left) : '0;
      res.last         = stat.drain_final;
    end
  end

  // Partition store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data <= mem[idx];
      rd_vld  <= cap_vld[idx];
      rd_used <= used[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req  <= in_item;
      sum  <= '0;
      rest <= in_item.amount;
    end else begin
      if (cmd.acc_sum && rd_used) begin
        sum <= sum + SW'(cap);
      end
      if (cmd.piece && !stat.drain_final) begin
        rest <= rest - ffba_pkg::AMOUNT_W'(cap);
      end
    end
    if (cmd.clr_idx) begin
      idx <= '0;
    end else if (cmd.inc_idx) begin
      idx <= idx + 1'b1;
    end
    if (emit) begin
      out_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_vld   <= '0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load && in_range) begin
        cap_vld[load_addr] <= 1'b1;
        used[load_addr]    <= 1'b0;
      end
      if (cmd.fit) begin
        used[idx] <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/first_fit_block_allocator.sv =====
// First-fit partition allocator.
// in_ch carries one item per transfer: mode 0 loads amount as the capacity of
// partition block_index and clears its used mark; mode 1 requests amount.
// out_ch carries the results. A load, a whole fit and a refusal give one
// result; a drain gives one result per partition drawn from, last high on the
// final one. Every input causes at least one result.
// The block takes one item at a time: in_ch.ready is high only while idle,
// even if a result still waits in the output register.
// Each partition visited is first addressed, then evaluated from the registered
// read port of the partition memory. The worst request scans the partitions
// three times (fit search, used sum, drain).
// When out_ch stalls, the result holds in the output register and the scan
// waits at the point of the next result; nothing is lost or repeated.
// Synchronous reset empties every partition and clears all used marks and
// the output valid flag at once; no clearing pass follows.
`default_nettype none
module first_fit_block_allocator #(
  parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = ffba_pkg::SIZE_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ffba_in_if.sink    in_ch,
  ffba_out_if.source out_ch
);

  ffba_pkg::cmd_t      cmd;
  ffba_pkg::stat_t     stat;
  ffba_pkg::in_item_t  in_item;
  ffba_pkg::out_item_t out_item;
  logic                in_ready;
  logic                out_valid;

  // Pack the input fields for capture.
  assign in_item.mode        = in_ch.mode;
  assign in_item.block_index = in_ch.block_index;
  assign in_item.amount      = in_ch.amount;
  assign in_ch.ready         = in_ready;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (out_ch.ready)
  );

  // Drive the result channel straight from the output register.
  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_item.status;
  assign out_ch.chosen_block = out_item.chosen_block;
  assign out_ch.amount_taken = out_item.amount_taken;
  assign out_ch.block_left   = out_item.block_left;
  assign out_ch.last         = out_item.last;

endmodule
`default_nettype wire

// ===== sv/ffba_checker.sv =====
`default_nettype none
`include "first_fit_block_allocator_macros.svh"
module ffba_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [ffba_pkg::STATUS_W-1:0] status,
  input wire logic [ffba_pkg::INDEX_W-1:0]  chosen_block,
  input wire logic [ffba_pkg::AMOUNT_W-1:0] amount_taken,
  input wire logic [ffba_pkg::AMOUNT_W-1:0] block_left,
  input wire logic                          last
);

  `FFBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(chosen_block) &&
    $stable(amount_taken) && $stable(block_left) && $stable(last))
  `FFBA_ASSERT_IMPL(a_refuse_form, out_valid && status == ffba_pkg::ST_REFUSE,
    last && chosen_block == '0 && amount_taken == '0 && block_left == '0)
  `FFBA_ASSERT_IMPL(a_single_last,
    out_valid && (status == ffba_pkg::ST_FIT || status == ffba_pkg::ST_LOAD), last)
  // A drain still owes its final piece, so the input stays closed.
  `FFBA_ASSERT_IMPL(a_drain_busy, out_valid && !last, !in_ready)
  `FFBA_ASSERT_NEXT(a_take_busy, in_valid && in_ready, !in_ready)

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .chosen_block (out_ch.chosen_block),
  .amount_taken (out_ch.amount_taken),
  .block_left   (out_ch.block_left),
  .last         (out_ch.last)
);
`default_nettype wire
